@@ sv/deq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// deq_pkg: shared constants and helpers for the double-ended queue
// ring depth, field widths, action and status codes, ring slot arithmetic
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH   = 16;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int VALUE_W = 32;
    localparam int ACT_W   = 3;
    localparam int POS_W   = 4;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);

    // request codes
    localparam logic [ACT_W-1:0] ACT_APPEND    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PREPEND   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_READ      = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DEL_FIRST = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DEL_LAST  = 3'd4;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STAT_W-1:0] ST_BADIDX = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

    // slot that lies offset places after base, modulo the ring depth
    function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] base,
                                                 input logic [PTR_W-1:0] offset);
        logic [PTR_W:0] sum;
        sum = {1'b0, base} + {1'b0, offset};
        if (sum >= (PTR_W+1)'(DEPTH))
        begin
            sum = sum - (PTR_W+1)'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage
`default_nettype wire

@@ sv/deq_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// deq_ram: generic simple dual-port ram
// one write port, one read port, read data registered
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

@@ sv/double_ended_queue_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue_core: bounded double-ended queue of signed 32-bit values
// ring store in a ram, front slot and entry count in registers
// ----------------------------------------------------------------------------
// usage
//   request channel: drive action, item_value and position with start high;
//   the item is taken at the rising edge where start is high and busy is low.
//   busy never rises, so one request can be taken in every cycle.
//   result channel: done is high for exactly one cycle, in the cycle after the
//   request was taken, with status, read_value and entry_total valid in that
//   cycle. the receiver cannot hold results back and needs none of that.
// throughput
//   1 request per cycle sustained. the ram read port (registered read) is
//   used by an indexed read; pointer and count updates are worked out in
//   the request cycle and registered at its end.
//   a write in one cycle and a read of the same slot in the next do not
//   collide, since the write lands at the edge before the read samples.
// reset
//   rst_n clears the front slot, the entry count and the result strobe.
//   the ring ram is not cleared: only slots written by a push are ever read.
// ----------------------------------------------------------------------------
module double_ended_queue_core
    import deq_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // request side
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [ACT_W-1:0]          action,
    input  wire logic signed [VALUE_W-1:0] item_value,
    input  wire logic [POS_W-1:0]          position,
    // result side
    output logic                           done,
    output logic [STAT_W-1:0]              status,
    output logic signed [VALUE_W-1:0]      read_value,
    output logic [COUNT_W-1:0]             entry_total
);

    // ring bookkeeping
    logic [PTR_W-1:0]   front_reg, front_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    // result stage
    logic               done_reg;
    logic [STAT_W-1:0]  status_reg, status_next;
    logic               good_rd_reg, good_rd_next;
    logic [COUNT_W-1:0] total_reg;

    // ram ports
    logic               wr_en;
    logic [PTR_W-1:0]   wr_addr;
    logic               rd_en;
    logic [PTR_W-1:0]   rd_addr;
    logic [VALUE_W-1:0] rd_data;

    logic accept;
    logic is_full;
    logic is_empty;

    // requests never wait: busy is tied low and every request is taken
    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign is_full  = (count_reg == FULL_COUNT);
    assign is_empty = (count_reg == '0);

    // ring store: one write port for pushes, one read port for indexed reads
    deq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (item_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // decode the request and work out the new pointers
    always_comb
    begin
        front_next   = front_reg;
        count_next   = count_reg;
        status_next  = ST_OK;
        good_rd_next = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = slot_of(front_reg, count_reg[PTR_W-1:0]);
        rd_en        = 1'b0;
        rd_addr      = slot_of(front_reg, PTR_W'(position));
        if (accept)
        begin
            case (action)
                ACT_APPEND:
                begin
                    // next free slot sits count places after the front
                    if (is_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + COUNT_W'(1);
                    end
                end
                ACT_PREPEND:
                begin
                    // front steps back one slot and takes the value
                    if (is_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        front_next = slot_of(front_reg, PTR_W'(DEPTH - 1));
                        wr_en      = 1'b1;
                        wr_addr    = front_next;
                        count_next = count_reg + COUNT_W'(1);
                    end
                end
                ACT_READ:
                begin
                    if (COUNT_W'(position) >= count_reg)
                    begin
                        status_next = ST_BADIDX;
                    end
                    else
                    begin
                        rd_en        = 1'b1;
                        good_rd_next = 1'b1;
                    end
                end
                ACT_DEL_FIRST:
                begin
                    if (is_empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        front_next = slot_of(front_reg, PTR_W'(1));
                        count_next = count_reg - COUNT_W'(1);
                    end
                end
                ACT_DEL_LAST:
                begin
                    if (is_empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - COUNT_W'(1);
                    end
                end
                default:
                begin
                    // unused codes leave the queue alone and report ok
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg   <= '0;
            count_reg   <= '0;
            done_reg    <= 1'b0;
            good_rd_reg <= 1'b0;
        end
        else
        begin
            front_reg   <= front_next;
            count_reg   <= count_next;
            done_reg    <= accept;
            good_rd_reg <= good_rd_next;
        end
    end

    // result payload needs no reset, it is only looked at with done
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            total_reg  <= count_next;
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign entry_total = total_reg;
    // ram data arrives with the result strobe; failed reads and other actions give zero
    assign read_value  = good_rd_reg ? $signed(rd_data) : '0;

    // count stays within the ring
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("entry count beyond ring depth");

    // each taken request yields one result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("request without result");

    a_no_stray_result: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> !done)
        else $error("result without request");

    // reported total matches the count that the request left behind
    a_total_matches: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> entry_total == count_reg)
        else $error("reported total differs from entry count");

    // a refused push never changes the bookkeeping
    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_full && (action == ACT_APPEND || action == ACT_PREPEND)
        |=> status == ST_FULL && $stable(count_reg) && $stable(front_reg))
        else $error("full push changed the queue");

endmodule
`default_nettype wire
